@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when cond holds, prop must hold too.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: implication");

// Next-cycle implication: when cond holds, prop must hold in the cycle after.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

@@ design/bfbp_pkg.sv @@
`default_nettype none

package bfbp_pkg;

   // Sizing of the bin row and the item size.
   localparam int MAX_BINS   = 256;
   localparam int SIZE_WIDTH = 8;
   localparam int BIN_IDX_W  = $clog2(MAX_BINS);
   localparam int COUNT_W    = $clog2(MAX_BINS + 1);

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [7:0] RESET_CAPACITY = 8'd10;

   typedef enum logic [1:0] {
      STATUS_PLACED   = 2'd0,
      STATUS_OVERSIZE = 2'd1,
      STATUS_NO_BIN   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] item_size;
      logic       last_item;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  chosen_bin;
      logic        opened_new;
      status_type  status;
      logic [8:0]  bins_in_use;
      logic [31:0] run_total;
   } rsp_word_type;

   // Search token that walks the row of cells.
   typedef struct packed {
      logic                  valid;
      logic [SIZE_WIDTH-1:0] size;
      logic                  found;
      logic [SIZE_WIDTH-1:0] best_left;
      logic [BIN_IDX_W-1:0]  best_idx;
   } probe_type;

   // Room update broadcast to all cells.
   typedef struct packed {
      logic                  valid;
      logic [BIN_IDX_W-1:0]  idx;
      logic [SIZE_WIDTH-1:0] room;
   } commit_type;

endpackage

`default_nettype wire

@@ design/bfbp_cell.sv @@
`default_nettype none

module bfbp_cell
   import bfbp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [BIN_IDX_W-1:0] cell_idx,
   input  wire logic [COUNT_W-1:0] open_count,
   input  wire probe_type          up_probe,
   input  wire commit_type         commit,
   output probe_type               down_probe
);

   logic [SIZE_WIDTH-1:0] room_ff;
   probe_type             probe_ff;
   probe_type             probe_in;
   logic                  is_open;
   logic                  fits;
   logic [SIZE_WIDTH-1:0] left;

   // Compare this bin against the best candidate so far
   assign is_open = COUNT_W'(cell_idx) < open_count;
   assign fits    = up_probe.valid && is_open && (room_ff >= up_probe.size);
   assign left    = room_ff - up_probe.size;

   always_comb begin
      probe_in = up_probe;
      if (fits && (!up_probe.found || (left < up_probe.best_left))) begin
         probe_in.found     = 1'b1;
         probe_in.best_left = left;
         probe_in.best_idx  = cell_idx;
      end
   end

   // Advance the token one cell
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   // Take the room update addressed to this bin
   always_ff @(posedge clock) begin
      if (commit.valid && (commit.idx == cell_idx)) begin
         room_ff <= commit.room;
      end
   end

   assign down_probe = probe_ff;

endmodule

`default_nettype wire

@@ design/best_fit_bin_packer.sv @@
// Best-fit online bin packer.
// Input channel req_*: one word per item (item_size, last_item), valid/ready.
// Result channel rsp_*: one word per item (chosen_bin, opened_new, status,
// bins_in_use, run_total), valid/ready, held in an output register.
// APB port csr_*: register 0 (byte address 0) is the capacity, reset value 10.
// Each bin's remaining room lives in one cell of a row of MAX_BINS cells.
// An accepted item sends a search token down the row, one cell per cycle;
// each cell keeps the better of its own fit and the incoming best fit.
// The result word is loaded once the token has left the cell row and the
// decision is made; a new item is taken only when the block is back in
// idle, after the result of the last item has been loaded.
// Items too large for the capacity, or that need a bin when all are open,
// return a reject status and change no bin. last_item closes the run: the
// bin count is added (saturating) to the total and all bins are freed.
// Reset frees all bins, clears the total and sets the capacity to 10.
// If the receiver stalls, the finished word waits in the output register
// and the block holds its decision until the word can be loaded.
`default_nettype none
`include "assert_macros.svh"

module best_fit_bin_packer
   import bfbp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_word_type          req_word,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_word_type               rsp_word,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE
   } state_type;

   state_type             state_ff;
   probe_type             inject_ff;
   probe_type             tail_ff;
   logic                  last_ff;
   logic [COUNT_W-1:0]    open_count_ff;
   logic [31:0]           total_ff;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;
   logic [7:0]            cap_ff;

   probe_type             chain_link [MAX_BINS+1];
   commit_type            commit;

   logic                  req_take;
   logic                  slot_free;
   logic                  dec_load;
   logic [SIZE_WIDTH-1:0] cap;
   status_type            dec_status;
   logic [BIN_IDX_W-1:0]  dec_idx;
   logic                  dec_opened;
   logic [COUNT_W-1:0]    count_after;
   logic [32:0]           total_sum;
   logic [31:0]           total_after;
   logic                  csr_write;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= RESET_CAPACITY;
      end else if (csr_write && (csr_paddr[CSR_ADDR_W-1] == REG_CAPACITY)) begin
         cap_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_CAPACITY) ? 32'(cap_ff) : '0;

   // Row of bin cells
   assign chain_link[0] = inject_ff;

   for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
      bfbp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (BIN_IDX_W'(k)),
         .open_count (open_count_ff),
         .up_probe   (chain_link[k]),
         .commit     (commit),
         .down_probe (chain_link[k+1])
      );
   end

   // Decide the placement once the token has left the row
   assign cap       = SIZE_WIDTH'(cap_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign dec_load  = (state_ff == S_DECIDE) && slot_free;

   always_comb begin
      dec_status  = STATUS_PLACED;
      dec_idx     = '0;
      dec_opened  = 1'b0;
      count_after = open_count_ff;
      commit      = '0;
      priority if (tail_ff.size > cap) begin
         dec_status = STATUS_OVERSIZE;
      end else if (tail_ff.found) begin
         dec_idx      = tail_ff.best_idx;
         commit.valid = dec_load;
         commit.idx   = tail_ff.best_idx;
         commit.room  = tail_ff.best_left;
      end else if (open_count_ff == COUNT_W'(MAX_BINS)) begin
         dec_status = STATUS_NO_BIN;
      end else begin
         dec_idx      = open_count_ff[BIN_IDX_W-1:0];
         dec_opened   = 1'b1;
         count_after  = open_count_ff + 1'b1;
         commit.valid = dec_load;
         commit.idx   = open_count_ff[BIN_IDX_W-1:0];
         commit.room  = cap - tail_ff.size;
      end
   end

   // Saturating run total
   assign total_sum = {1'b0, total_ff} + 33'(count_after);
   always_comb begin
      total_after = total_ff;
      if (last_ff) begin
         total_after = total_sum[32] ? '1 : total_sum[31:0];
      end
   end

   // Sequencer and output register
   assign req_take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         inject_ff.valid <= 1'b0;
         open_count_ff   <= '0;
         total_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         inject_ff.valid <= req_take;
         if (dec_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  inject_ff.size      <= SIZE_WIDTH'(req_word.item_size);
                  inject_ff.found     <= 1'b0;
                  inject_ff.best_left <= '0;
                  inject_ff.best_idx  <= '0;
                  last_ff             <= req_word.last_item;
                  state_ff            <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (chain_link[MAX_BINS].valid) begin
                  tail_ff  <= chain_link[MAX_BINS];
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (slot_free) begin
                  rsp_word_ff.chosen_bin  <= 8'(dec_idx);
                  rsp_word_ff.opened_new  <= dec_opened;
                  rsp_word_ff.status      <= dec_status;
                  rsp_word_ff.bins_in_use <= 9'(count_after);
                  rsp_word_ff.run_total   <= total_after;
                  open_count_ff           <= last_ff ? '0 : count_after;
                  total_ff                <= total_after;
                  state_ff                <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks
   `ASSERT_IMPLIES(a_open_bound, clock, reset, 1'b1, open_count_ff <= COUNT_W'(MAX_BINS))
   `ASSERT_NEXT(a_inject_on_take, clock, reset, req_take, inject_ff.valid && state_ff == S_SEARCH)
   `ASSERT_IMPLIES(a_tail_in_search, clock, reset, chain_link[MAX_BINS].valid, state_ff == S_SEARCH)

endmodule

`default_nettype wire
